>>> rtl/core/rrts_pkg.sv
package rrts_pkg;

    // sizes of the queues and of the thread table
    localparam int QUEUE_DEPTH  = 16;
    localparam int THREAD_COUNT = 16;

    localparam int THREAD_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int TID_W    = 4;
    localparam int TST_W    = 2;
    localparam int STATUS_W = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_YIELD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_EXIT    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESUME  = 3'd4;
    localparam logic [OP_W-1:0] OP_START   = 3'd5;

    // thread states
    localparam logic [TST_W-1:0] TST_READY    = 2'd0;
    localparam logic [TST_W-1:0] TST_RUNNING  = 2'd1;
    localparam logic [TST_W-1:0] TST_WAITING  = 2'd2;
    localparam logic [TST_W-1:0] TST_FINISHED = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;

    // queue control and status
    typedef struct packed {
        logic rd_en;
        logic pop;
        logic push;
    } fifo_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    // thread table access
    typedef struct packed {
        logic                rd_en;
        logic [THREAD_W-1:0] rd_addr;
        logic                wr_en;
        logic [THREAD_W-1:0] wr_addr;
        logic [TST_W-1:0]    wr_data;
    } tbl_cmd_t;

endpackage

>>> rtl/core/rrts_ram.sv
module rrts_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read that holds when idle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/rrts_fifo.sv
module rrts_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rrts_pkg::fifo_cmd_t            cmd,
    input  logic [rrts_pkg::THREAD_W-1:0]  wdata,
    output logic [rrts_pkg::THREAD_W-1:0]  rdata,
    output rrts_pkg::fifo_stat_t           stat
);

    logic [rrts_pkg::PTR_W-1:0] head_reg, head_next;
    logic [rrts_pkg::PTR_W-1:0] tail_reg, tail_next;
    logic [rrts_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       full;
    logic                       push_ok;

    assign full    = (count_reg == rrts_pkg::CNT_W'(rrts_pkg::QUEUE_DEPTH));
    // a pop in the same beat frees a slot for the push
    assign push_ok = cmd.push && (!full || cmd.pop);

    assign stat.empty = (count_reg == '0);
    assign stat.full  = full;

    // pointer and fill count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            head_next = (head_reg == rrts_pkg::PTR_W'(rrts_pkg::QUEUE_DEPTH - 1))
                        ? '0 : head_reg + 1'b1;
        end
        if (push_ok)
        begin
            tail_next = (tail_reg == rrts_pkg::PTR_W'(rrts_pkg::QUEUE_DEPTH - 1))
                        ? '0 : tail_reg + 1'b1;
        end
        if (push_ok && !cmd.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_ok && cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    rrts_ram #(
        .WIDTH (rrts_pkg::THREAD_W),
        .DEPTH (rrts_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (tail_reg),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (head_reg),
        .rdata (rdata)
    );

endmodule

>>> rtl/core/rrts_thread_table.sv
module rrts_thread_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rrts_pkg::tbl_cmd_t          cmd,
    output logic [rrts_pkg::TST_W-1:0]  rd_data
);

    logic [rrts_pkg::THREAD_COUNT-1:0] valid_reg, valid_next;
    logic                              valid_q_reg;
    logic                              fwd_hit_reg;
    logic [rrts_pkg::TST_W-1:0]        fwd_data_reg;
    logic [rrts_pkg::TST_W-1:0]        ram_rdata;

    // an entry never written reads as ready
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.wr_en)
        begin
            valid_next[cmd.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.rd_en)
            begin
                valid_q_reg <= valid_reg[cmd.rd_addr];
                fwd_hit_reg <= cmd.wr_en && (cmd.wr_addr == cmd.rd_addr);
            end
        end
    end

    // forward a write that lands on the entry being read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            fwd_data_reg <= cmd.wr_data;
        end
    end

    rrts_ram #(
        .WIDTH (rrts_pkg::TST_W),
        .DEPTH (rrts_pkg::THREAD_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_addr),
        .wdata (cmd.wr_data),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (ram_rdata)
    );

    assign rd_data = fwd_hit_reg ? fwd_data_reg
                   : (valid_q_reg ? ram_rdata : rrts_pkg::TST_READY);

endmodule

>>> rtl/core/round_robin_thread_scheduler.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid / in_stall  | opcode, thread_id
// out      | output    | out_valid / out_stall| switched, from_thread, to_thread,
//          |           |                      | from_state, status
//
// each beat first reads the ready queue head and the thread table entry of the
// running thread, then updates and writes back.
// the new running thread is marked in the table in the following idle cycle,
// which overlaps the next beat's read and is forwarded to it.
// reset clears pointers, counts, table valid bits and the running thread; no
// clearing pass is needed. a stalled result holds the update step until taken.
module round_robin_thread_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rrts_pkg::OP_W-1:0]      opcode,
    input  logic [rrts_pkg::TID_W-1:0]     thread_id,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           switched,
    output logic [rrts_pkg::TID_W-1:0]     from_thread,
    output logic [rrts_pkg::TID_W-1:0]     to_thread,
    output logic [rrts_pkg::TST_W-1:0]     from_state,
    output logic [rrts_pkg::STATUS_W-1:0]  status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } fsm_t;

    fsm_t                            state_reg, state_next;
    logic [rrts_pkg::OP_W-1:0]       op_reg;
    logic [rrts_pkg::TID_W-1:0]      tid_reg;
    logic [rrts_pkg::THREAD_W-1:0]   running_reg, running_next;
    logic                            first_tick_reg, first_tick_next;
    logic                            pend_reg, pend_next;
    logic [rrts_pkg::THREAD_W-1:0]   pend_addr_reg, pend_addr_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            switched_reg, switched_next;
    logic [rrts_pkg::TID_W-1:0]      from_thread_reg, from_thread_next;
    logic [rrts_pkg::TID_W-1:0]      to_thread_reg, to_thread_next;
    logic [rrts_pkg::TST_W-1:0]      from_state_reg, from_state_next;
    logic [rrts_pkg::STATUS_W-1:0]   status_reg, status_next;

    rrts_pkg::fifo_cmd_t             rdy_cmd, fin_cmd;
    rrts_pkg::fifo_stat_t            rdy_stat, fin_stat;
    logic [rrts_pkg::THREAD_W-1:0]   rdy_wdata;
    logic [rrts_pkg::THREAD_W-1:0]   rdy_rdata;
    rrts_pkg::tbl_cmd_t              tbl_cmd;
    logic [rrts_pkg::TST_W-1:0]      old_state;

    logic                            accept;
    logic                            go;
    logic                            is_switch;
    logic                            tid_ok;
    logic [rrts_pkg::TST_W-1:0]      retire_state;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign go       = (state_reg == S_EXEC) && !(out_valid_reg && out_stall);

    assign is_switch = op_reg inside {rrts_pkg::OP_TICK, rrts_pkg::OP_YIELD,
                                      rrts_pkg::OP_SUSPEND, rrts_pkg::OP_EXIT,
                                      rrts_pkg::OP_START};
    assign tid_ok    = (32'(tid_reg) < rrts_pkg::THREAD_COUNT);

    // state the old thread takes on a switch
    always_comb
    begin
        case (op_reg)
            rrts_pkg::OP_SUSPEND: retire_state = rrts_pkg::TST_WAITING;
            rrts_pkg::OP_EXIT:    retire_state = rrts_pkg::TST_FINISHED;
            default:              retire_state = rrts_pkg::TST_READY;
        endcase
    end

    // sequencing, queue and table commands, result
    always_comb
    begin
        state_next       = state_reg;
        running_next     = running_reg;
        first_tick_next  = first_tick_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        out_valid_next   = out_valid_reg && out_stall;
        switched_next    = switched_reg;
        from_thread_next = from_thread_reg;
        to_thread_next   = to_thread_reg;
        from_state_next  = from_state_reg;
        status_next      = status_reg;

        rdy_cmd   = '0;
        fin_cmd   = '0;
        rdy_wdata = running_reg;
        tbl_cmd   = '0;
        tbl_cmd.rd_addr = running_reg;

        case (state_reg)
            S_IDLE:
            begin
                // mark the thread switched in on the last beat
                if (pend_reg)
                begin
                    tbl_cmd.wr_en   = 1'b1;
                    tbl_cmd.wr_addr = pend_addr_reg;
                    tbl_cmd.wr_data = rrts_pkg::TST_RUNNING;
                    pend_next       = 1'b0;
                end
                if (accept)
                begin
                    tbl_cmd.rd_en = 1'b1;
                    rdy_cmd.rd_en = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go)
                begin
                    state_next       = S_IDLE;
                    out_valid_next   = 1'b1;
                    switched_next    = 1'b0;
                    from_thread_next = rrts_pkg::TID_W'(running_reg);
                    to_thread_next   = rrts_pkg::TID_W'(running_reg);
                    from_state_next  = rrts_pkg::TST_READY;
                    status_next      = rrts_pkg::STATUS_OK;
                    if (is_switch)
                    begin
                        if (rdy_stat.empty)
                        begin
                            status_next = rrts_pkg::STATUS_NO_READY;
                        end
                        else
                        begin
                            // take the head thread and requeue or retire the old one
                            rdy_cmd.pop     = 1'b1;
                            running_next    = rdy_rdata;
                            pend_next       = 1'b1;
                            pend_addr_next  = rdy_rdata;
                            switched_next   = 1'b1;
                            to_thread_next  = rrts_pkg::TID_W'(rdy_rdata);
                            if (op_reg != rrts_pkg::OP_START)
                            begin
                                tbl_cmd.wr_en   = 1'b1;
                                tbl_cmd.wr_addr = running_reg;
                                tbl_cmd.wr_data = retire_state;
                            end
                            if (rdy_rdata == running_reg)
                            begin
                                from_state_next = rrts_pkg::TST_RUNNING;
                            end
                            else if (op_reg == rrts_pkg::OP_START)
                            begin
                                from_state_next = old_state;
                            end
                            else
                            begin
                                from_state_next = retire_state;
                            end
                            if (op_reg == rrts_pkg::OP_TICK)
                            begin
                                rdy_cmd.push    = !first_tick_reg;
                                first_tick_next = 1'b0;
                            end
                            else if (op_reg == rrts_pkg::OP_YIELD)
                            begin
                                rdy_cmd.push = 1'b1;
                            end
                            else if (op_reg == rrts_pkg::OP_EXIT)
                            begin
                                fin_cmd.push = 1'b1;
                                if (fin_stat.full)
                                begin
                                    status_next = rrts_pkg::STATUS_DROPPED;
                                end
                            end
                        end
                    end
                    else if ((op_reg == rrts_pkg::OP_RESUME) && tid_ok)
                    begin
                        // mark ready and queue it
                        tbl_cmd.wr_en   = 1'b1;
                        tbl_cmd.wr_addr = rrts_pkg::THREAD_W'(tid_reg);
                        tbl_cmd.wr_data = rrts_pkg::TST_READY;
                        rdy_cmd.push    = 1'b1;
                        rdy_wdata       = rrts_pkg::THREAD_W'(tid_reg);
                        if (rdy_stat.full)
                        begin
                            status_next = rrts_pkg::STATUS_DROPPED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            running_reg    <= '0;
            first_tick_reg <= 1'b1;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            first_tick_reg <= first_tick_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            tid_reg <= thread_id;
        end
        switched_reg    <= switched_next;
        from_thread_reg <= from_thread_next;
        to_thread_reg   <= to_thread_next;
        from_state_reg  <= from_state_next;
        status_reg      <= status_next;
    end

    // ready queue
    rrts_fifo u_ready_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rdy_cmd),
        .wdata (rdy_wdata),
        .rdata (rdy_rdata),
        .stat  (rdy_stat)
    );

    // finished queue, never popped in this design
    rrts_fifo u_finished_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fin_cmd),
        .wdata (running_reg),
        .rdata (),
        .stat  (fin_stat)
    );

    // per-thread state
    rrts_thread_table u_thread_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tbl_cmd),
        .rd_data (old_state)
    );

    assign out_valid   = out_valid_reg;
    assign switched    = switched_reg;
    assign from_thread = from_thread_reg;
    assign to_thread   = to_thread_reg;
    assign from_state  = from_state_reg;
    assign status      = status_reg;

endmodule
